@@ rtl/led_pattern_effect_engine_defines.svh @@
// ----------------------------------------------------------------------------
// led_pattern_effect_engine_defines
// Assertion macros used by the checker file (lpe_checker).
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_EFFECT_ENGINE_DEFINES_SVH
`define LED_PATTERN_EFFECT_ENGINE_DEFINES_SVH

// same-cycle implication, masked during reset
`define LPE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define LPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define LPE_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lpe_pkg.sv @@
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants for the LED pattern effect engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpe_pkg;

  localparam int NUM_OUT    = 6;
  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 32;
  localparam int IV_W       = 16;
  localparam int INC_W      = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = NUM_OUT * LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'h00;

  localparam logic [IV_W-1:0]  RST_STEP_IV   = 16'd50;
  localparam logic [IV_W-1:0]  RST_BOUNCE_IV = 16'd30;
  localparam logic [INC_W-1:0] RST_FADE_INC  = 8'd15;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_IV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INC  = 2'd3;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_BOUNCE = 2'd1,
    MODE_FADE   = 2'd2,
    MODE_FILL   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [IV_W-1:0]   step_iv;
    logic [IV_W-1:0]   bounce_iv;
    logic [INC_W-1:0]  fade_inc;
  } cfg_t;

endpackage

@@ rtl/led_pattern_effect_engine.sv @@
// ----------------------------------------------------------------------------
// led_pattern_effect_engine
// Pipeline: input register, then result register; a stalled result holds the input.
// Throughput: one tick per cycle unless the result stalls; single-pass state update.
// Reset (rst_n, sync): clears pipeline valids and effect state, loads defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_pattern_effect_engine #(
  parameter int LED_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lpe_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lpe_pkg::OUT_DATA_W-1:0] out_tdata,  // level_0 .. level_5, 8b each
  output logic                           out_tuser,  // [0] stepped
  input  logic                           cfg_we,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpe_pkg::CFG_W-1:0]      cfg_wdata
);
  import lpe_pkg::*;

  cfg_t                  cfg;
  logic                  in_valid_r;
  logic [TIME_W-1:0]     now_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  adv;
  logic                  due;
  logic [OUT_DATA_W-1:0] report_nxt;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  lpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpe_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (adv),
    .now   (now_r),
    .cfg   (cfg),
    .due   (due)
  );

  lpe_effect #(
    .LED_COUNT (LED_COUNT)
  ) u_effect (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (adv),
    .due        (due),
    .cfg        (cfg),
    .report_nxt (report_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r <= in_tdata[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= report_nxt;
      out_user_r <= due;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ rtl/lpe_cfg.sv @@
// ----------------------------------------------------------------------------
// lpe_cfg
// Configuration register bank, written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpe_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpe_pkg::CFG_W-1:0]     cfg_wdata,
  output lpe_pkg::cfg_t                 cfg
);
  import lpe_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_OFF;
      cfg_r.step_iv   <= RST_STEP_IV;
      cfg_r.bounce_iv <= RST_BOUNCE_IV;
      cfg_r.fade_inc  <= RST_FADE_INC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      cfg_r.mode      <= mode_t'(cfg_wdata[1:0]);
        REG_STEP_IV:   cfg_r.step_iv   <= cfg_wdata[IV_W-1:0];
        REG_BOUNCE_IV: cfg_r.bounce_iv <= cfg_wdata[IV_W-1:0];
        REG_FADE_INC:  cfg_r.fade_inc  <= cfg_wdata[INC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/lpe_timer.sv @@
// ----------------------------------------------------------------------------
// lpe_timer
// Shared step timestamp and wrapping elapsed-time compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpe_timer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd,
  input  logic [lpe_pkg::TIME_W-1:0] now,
  input  lpe_pkg::cfg_t              cfg,
  output logic                       due
);
  import lpe_pkg::*;

  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] elapsed;
  logic [IV_W-1:0]   iv;

  assign elapsed = now - last_r;
  assign iv      = (cfg.mode == MODE_BOUNCE) ? cfg.bounce_iv : cfg.step_iv;
  assign due     = (cfg.mode != MODE_OFF) && (elapsed > {{(TIME_W-IV_W){1'b0}}, iv});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (upd && due) begin
      last_r <= now;
    end
  end

endmodule

@@ rtl/lpe_effect.sv @@
// ----------------------------------------------------------------------------
// lpe_effect
// Effect state and LED levels: off, bounce, fade and fill step logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpe_effect #(
  parameter int LED_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic                           due,
  input  lpe_pkg::cfg_t                  cfg,
  output logic [lpe_pkg::OUT_DATA_W-1:0] report_nxt
);
  import lpe_pkg::*;

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W-1:0] FIRST = '0;

  logic [LEVEL_W-1:0] level_r   [LED_COUNT];
  logic [LEVEL_W-1:0] level_nxt [LED_COUNT];

  logic [LEVEL_W-1:0] fade_lvl_r, fade_lvl_nxt;
  logic               fade_fall_r, fade_fall_nxt;
  logic [IDX_W-1:0]   bnc_idx_r, bnc_idx_nxt;
  logic               bnc_down_r, bnc_down_nxt;
  logic [IDX_W-1:0]   fill_idx_r, fill_idx_nxt;
  logic               fill_on_r, fill_on_nxt;
  logic               fill_rev_r, fill_rev_nxt;

  logic [IDX_W-1:0]   bnc_cur, fill_cur, bnc_mov;
  logic [LEVEL_W:0]   fade_sum;

  assign bnc_cur  = (bnc_idx_r > LAST) ? LAST : bnc_idx_r;
  assign fill_cur = (fill_idx_r > LAST) ? LAST : fill_idx_r;
  assign fade_sum = {1'b0, fade_lvl_r} + {1'b0, cfg.fade_inc};

  always_comb begin
    if (!bnc_down_r) begin
      bnc_mov = (bnc_cur < LAST) ? bnc_cur + 1'b1 : bnc_cur;
    end else begin
      bnc_mov = (bnc_cur > FIRST) ? bnc_cur - 1'b1 : bnc_cur;
    end
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      level_nxt[i] = level_r[i];
    end
    fade_lvl_nxt  = fade_lvl_r;
    fade_fall_nxt = fade_fall_r;
    bnc_idx_nxt   = bnc_idx_r;
    bnc_down_nxt  = bnc_down_r;
    fill_idx_nxt  = fill_idx_r;
    fill_on_nxt   = fill_on_r;
    fill_rev_nxt  = fill_rev_r;

    unique case (cfg.mode)
      MODE_OFF: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          level_nxt[i] = LEVEL_OFF;
        end
      end
      MODE_BOUNCE: begin
        if (due) begin
          for (int i = 0; i < LED_COUNT; i++) begin
            level_nxt[i] = (IDX_W'(i) == bnc_cur) ? LEVEL_FULL : LEVEL_OFF;
          end
          bnc_idx_nxt  = bnc_mov;
          bnc_down_nxt = ((bnc_mov == LAST) || (bnc_mov == FIRST)) ? !bnc_down_r
                                                                   : bnc_down_r;
        end
      end
      MODE_FADE: begin
        if (due) begin
          for (int i = 0; i < LED_COUNT; i++) begin
            level_nxt[i] = fade_lvl_r;
          end
          if (!fade_fall_r) begin
            if (fade_sum >= {1'b0, LEVEL_FULL}) begin
              fade_lvl_nxt  = LEVEL_FULL;
              fade_fall_nxt = 1'b1;
            end else begin
              fade_lvl_nxt = fade_sum[LEVEL_W-1:0];
            end
          end else begin
            if (fade_lvl_r <= cfg.fade_inc) begin
              fade_lvl_nxt  = LEVEL_OFF;
              fade_fall_nxt = 1'b0;
            end else begin
              fade_lvl_nxt = fade_lvl_r - cfg.fade_inc;
            end
          end
        end
      end
      MODE_FILL: begin
        if (due) begin
          for (int i = 0; i < LED_COUNT; i++) begin
            if (IDX_W'(i) == fill_cur) begin
              level_nxt[i] = fill_on_r ? LEVEL_FULL : LEVEL_OFF;
            end
          end
          fill_idx_nxt = fill_cur;
          if (!fill_rev_r) begin
            if (fill_cur == LAST) begin
              if (!fill_on_r) begin
                fill_rev_nxt = 1'b1;
                fill_on_nxt  = 1'b1;
              end else begin
                fill_idx_nxt = FIRST;
                fill_on_nxt  = 1'b0;
              end
            end else begin
              fill_idx_nxt = fill_cur + 1'b1;
            end
          end else begin
            if (fill_cur == FIRST) begin
              if (!fill_on_r) begin
                fill_rev_nxt = 1'b0;
                fill_on_nxt  = 1'b1;
              end else begin
                fill_idx_nxt = LAST;
                fill_on_nxt  = 1'b0;
              end
            end else begin
              fill_idx_nxt = fill_cur - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        level_r[i] <= LEVEL_OFF;
      end
      fade_lvl_r  <= LEVEL_OFF;
      fade_fall_r <= 1'b0;
      bnc_idx_r   <= FIRST;
      bnc_down_r  <= 1'b0;
      fill_idx_r  <= FIRST;
      fill_on_r   <= 1'b1;
      fill_rev_r  <= 1'b0;
    end else if (upd) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        level_r[i] <= level_nxt[i];
      end
      fade_lvl_r  <= fade_lvl_nxt;
      fade_fall_r <= fade_fall_nxt;
      bnc_idx_r   <= bnc_idx_nxt;
      bnc_down_r  <= bnc_down_nxt;
      fill_idx_r  <= fill_idx_nxt;
      fill_on_r   <= fill_on_nxt;
      fill_rev_r  <= fill_rev_nxt;
    end
  end

  // LEDs beyond the reported six are kept; missing ones report as off
  for (genvar j = 0; j < NUM_OUT; j++) begin : g_report
    if (j < LED_COUNT) begin : g_led
      assign report_nxt[j*LEVEL_W +: LEVEL_W] = level_nxt[j];
    end else begin : g_none
      assign report_nxt[j*LEVEL_W +: LEVEL_W] = LEVEL_OFF;
    end
  end

endmodule

@@ rtl/lpe_checker.sv @@
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the LED pattern effect engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_pattern_effect_engine_defines.svh"

module lpe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lpe_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import lpe_pkg::*;

  `LPE_ASSERT_RST(a_rst_clears_out, !rst_n, !out_tvalid, "result valid after reset")
  `LPE_ASSERT_SAME(a_no_back_stall, out_tready, in_tready, "input stalled while output drains")
  `LPE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped on stall")
  `LPE_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready,
                   $stable(out_tdata) && $stable(out_tuser), "result changed on stall")

endmodule

bind led_pattern_effect_engine lpe_checker u_lpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ sim/led_pattern_effect_engine_test.sv @@
// ----------------------------------------------------------------------------
// led_pattern_effect_engine_test
// Feeds millisecond ticks into the LED effect engine under every mode and a
// range of register settings, keeps its own model of the bounce, fade and
// fill sequences, and checks every LED level and step flag on the result
// stream. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_pattern_effect_engine_test;
  import lpe_pkg::*;

  localparam int LEDS            = 6;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASE_ITEMS     = 75;

  typedef struct packed {
    logic [NUM_OUT-1:0][LEVEL_W-1:0] levels;
    logic                            stepped;
  } led_frame_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [31:0] now_ms
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // level_0 .. level_5, 8b each
  logic                  out_tuser;         // [0] stepped
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // effect model state
  mode_t                      cur_mode;
  logic [IV_W-1:0]            step_iv;
  logic [IV_W-1:0]            bounce_iv;
  logic [INC_W-1:0]           fade_inc;
  logic [TIME_W-1:0]          tick_mark;
  logic [LEDS-1:0][LEVEL_W-1:0] led_lvl;
  int                         fade_lvl;
  bit                         fade_dn;
  int                         bnc_idx;
  bit                         bnc_dn;
  int                         fill_idx;
  bit                         fill_on;
  bit                         fill_rev;

  led_frame_t pending_frames[$];
  int         errors          = 0;
  int         frames_checked  = 0;
  int         steps_by_mode[4];
  int         settings_used;
  int         tx_gap_pct;
  int         rx_pause_pct;
  int         hold_off_requests;
  int         hold_off_served = 0;
  int         rx_stall_left   = 0;
  int         cycle_count     = 0;

  led_pattern_effect_engine #(.LED_COUNT(LEDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic void reset_model();
    cur_mode  = MODE_OFF;
    step_iv   = RST_STEP_IV;
    bounce_iv = RST_BOUNCE_IV;
    fade_inc  = RST_FADE_INC;
    tick_mark = '0;
    led_lvl   = '0;
    fade_lvl  = 0;
    fade_dn   = 1'b0;
    bnc_idx   = 0;
    bnc_dn    = 1'b0;
    fill_idx  = 0;
    fill_on   = 1'b1;
    fill_rev  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_MODE:      cur_mode  = mode_t'(val[1:0]);
      REG_STEP_IV:   step_iv   = val[IV_W-1:0];
      REG_BOUNCE_IV: bounce_iv = val[IV_W-1:0];
      REG_FADE_INC:  fade_inc  = val[INC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit step_is_due(logic [TIME_W-1:0] now, logic [IV_W-1:0] iv);
    logic [TIME_W-1:0] span;
    span = now - tick_mark;
    if (span > TIME_W'(iv)) begin
      tick_mark = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void bounce_advance();
    if (bnc_idx >= LEDS) bnc_idx = LEDS - 1;
    led_lvl = '0;
    led_lvl[bnc_idx] = LEVEL_FULL;
    if (!bnc_dn) begin
      if (bnc_idx < LEDS - 1) bnc_idx++;
    end else if (bnc_idx > 0) begin
      bnc_idx--;
    end
    if (bnc_idx == LEDS - 1 || bnc_idx == 0) bnc_dn = !bnc_dn;
  endfunction

  function automatic void fade_advance();
    for (int i = 0; i < LEDS; i++) led_lvl[i] = LEVEL_W'(fade_lvl);
    if (!fade_dn) begin
      fade_lvl += fade_inc;
      if (fade_lvl >= 255) begin
        fade_lvl = 255;
        fade_dn  = 1'b1;
      end
    end else if (fade_lvl <= fade_inc) begin
      fade_lvl = 0;
      fade_dn  = 1'b0;
    end else begin
      fade_lvl -= fade_inc;
    end
  endfunction

  function automatic void fill_advance();
    if (fill_idx >= LEDS) fill_idx = LEDS - 1;
    led_lvl[fill_idx] = fill_on ? LEVEL_FULL : LEVEL_OFF;
    if (!fill_rev) begin
      if (fill_idx == LEDS - 1) begin
        if (!fill_on) begin
          fill_rev = 1'b1;
          fill_on  = 1'b1;
        end else begin
          fill_idx = 0;
          fill_on  = 1'b0;
        end
      end else begin
        fill_idx++;
      end
    end else begin
      if (fill_idx == 0) begin
        if (!fill_on) begin
          fill_rev = 1'b0;
          fill_on  = 1'b1;
        end else begin
          fill_idx = LEDS - 1;
          fill_on  = 1'b0;
        end
      end else begin
        fill_idx--;
      end
    end
  endfunction

  // works out the frame that one tick produces and queues it
  function automatic void advance_effect(logic [TIME_W-1:0] now);
    led_frame_t frame;
    bit         did_step;
    did_step = 1'b0;
    case (cur_mode)
      MODE_BOUNCE: if (step_is_due(now, bounce_iv)) begin
        bounce_advance();
        did_step = 1'b1;
      end
      MODE_FADE: if (step_is_due(now, step_iv)) begin
        fade_advance();
        did_step = 1'b1;
      end
      MODE_FILL: if (step_is_due(now, step_iv)) begin
        fill_advance();
        did_step = 1'b1;
      end
      default: led_lvl = '0;
    endcase
    if (did_step) steps_by_mode[cur_mode]++;
    frame.levels  = led_lvl[NUM_OUT-1:0];
    frame.stepped = did_step;
    pending_frames.push_back(frame);
  endfunction

  // tick times around the step threshold, across the wrap and at random
  function automatic logic [TIME_W-1:0] next_tick();
    logic [TIME_W-1:0] iv;
    int                pick;
    iv   = TIME_W'((cur_mode == MODE_BOUNCE) ? bounce_iv : step_iv);
    pick = $urandom_range(99);
    if (pick < 45) return tick_mark + iv + 1 + $urandom_range(2);
    if (pick < 63) return tick_mark + $urandom_range(iv);
    if (pick < 70) return tick_mark + iv;
    if (pick < 80) return $urandom();
    if (pick < 87) return tick_mark - $urandom_range(200);
    if (pick < 94) return 32'hFFFF_FFFF - $urandom_range(iv);
    return $urandom_range(iv + 1);
  endfunction

  task automatic send_tick(input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_effect(now);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] v_mode, input logic [CFG_W-1:0] v_step,
                              input logic [CFG_W-1:0] v_bounce, input logic [CFG_W-1:0] v_inc);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_W-1:0]     val[4];
    idx = '{REG_MODE, REG_STEP_IV, REG_BOUNCE_IV, REG_FADE_INC};
    val = '{v_mode, v_step, v_bounce, v_inc};
    settle();
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[r];
      cfg_wdata <= val[r];
      @(posedge clk);
      apply_reg(idx[r], val[r]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic check_result();
    led_frame_t want;
    if (pending_frames.size() == 0) begin
      $display("%0t ns: result with nothing expected: levels=%h stepped=%b",
               $time, out_tdata, out_tuser);
      errors++;
      return;
    end
    want = pending_frames.pop_front();
    frames_checked++;
    for (int i = 0; i < NUM_OUT; i++) begin
      if (out_tdata[LEVEL_W*i +: LEVEL_W] !== want.levels[i]) begin
        $display("%0t ns: level_%0d expected %0d actual %0d", $time, i, want.levels[i],
                 out_tdata[LEVEL_W*i +: LEVEL_W]);
        errors++;
      end
    end
    if (out_tuser !== want.stepped) begin
      $display("%0t ns: stepped expected %b actual %b", $time, want.stepped, out_tuser);
      errors++;
    end
  endtask

  // result side: checking and ready, with random stalls and the long hold-off
  always @(posedge clk) begin
    int gap;
    if (rst_n && out_tvalid && out_tready) check_result();
    if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_requests;
      rx_stall_left   <= HOLD_OFF_CYCLES;
      out_tready      <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else begin
      gap = pick_gap(rx_pause_pct);
      if (gap > 0) begin
        out_tready    <= 1'b0;
        rx_stall_left <= gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_off_after_reset();
    tx_gap_pct   = 30;
    rx_pause_pct = 30;
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h8000_0000);
  endtask

  task automatic test_step_threshold();
    program_regs(16'(MODE_BOUNCE), 16'd50, 16'd30, 16'd15);
    send_tick(tick_mark + 32'd30);
    send_tick(tick_mark + 32'd31);
    program_regs(16'(MODE_BOUNCE), 16'd50, 16'd0, 16'd15);
    send_tick(tick_mark);
    send_tick(tick_mark + 32'd1);
    program_regs(16'(MODE_BOUNCE), 16'd50, 16'hFFFF, 16'd15);
    send_tick(tick_mark + 32'd65535);
    send_tick(tick_mark + 32'd65536);
  endtask

  task automatic test_fade_clamp();
    program_regs(16'(MODE_FADE), 16'd0, 16'd30, 16'hFFFF);
    repeat (4) send_tick(tick_mark + 32'd1);
    // zero increment: high bits of the write are dropped
    program_regs(16'(MODE_FADE), 16'd0, 16'd30, 16'h1200);
    repeat (2) send_tick(tick_mark + 32'd1);
  endtask

  task automatic test_fill_and_off();
    program_regs(16'(MODE_FILL), 16'd0, 16'd30, 16'd15);
    repeat (8) send_tick(tick_mark + 32'd1);
    // off mode with junk in the upper bits: clears, keeps fill position
    program_regs(16'hFFFC, 16'd0, 16'd30, 16'd15);
    send_tick(tick_mark + 32'd100);
    send_tick($urandom());
  endtask

  task automatic test_random_phases();
    logic [1:0]       mode;
    logic [CFG_W-1:0] s_iv;
    logic [CFG_W-1:0] b_iv;
    logic [CFG_W-1:0] inc;
    for (int p = 0; p < 11; p++) begin
      mode = 2'($urandom_range(3));
      s_iv = 16'($urandom_range(60));
      b_iv = 16'($urandom_range(60));
      inc  = {8'($urandom()), 8'($urandom_range(255, 1))};
      tx_gap_pct   = $urandom_range(40, 5);
      rx_pause_pct = $urandom_range(40, 5);
      case (p)
        0: begin
          mode = MODE_FILL;
          s_iv = 16'd0;
          tx_gap_pct   = 0;
          rx_pause_pct = 0;
        end
        1: begin
          mode = MODE_BOUNCE;
          b_iv = 16'hFFFF;
        end
        2: begin
          mode = MODE_FADE;
          inc  = 16'h0001;
        end
        3: begin
          mode = MODE_FADE;
          s_iv = 16'hFFFF;
          inc  = 16'hABFF;
        end
        4: begin
          mode = MODE_FADE;
          inc  = 16'h5500;
        end
        5: mode = MODE_FILL;
        6: begin
          mode = MODE_BOUNCE;
          b_iv = 16'd0;
        end
        7: begin
          mode = MODE_OFF;
          s_iv = 16'($urandom());
          b_iv = 16'($urandom());
        end
        default: begin
          s_iv = ($urandom_range(3) == 0) ? 16'($urandom()) : s_iv;
          b_iv = ($urandom_range(3) == 0) ? 16'($urandom()) : b_iv;
        end
      endcase
      program_regs({14'($urandom()), mode}, s_iv, b_iv, inc);
      repeat (PHASE_ITEMS) send_tick(next_tick());
    end
  endtask

  task automatic test_backpressure();
    program_regs(16'(MODE_FILL), 16'd2, 16'd2, 16'd40);
    tx_gap_pct   = 0;
    rx_pause_pct = 10;
    hold_off_requests++;
    repeat (30) send_tick(next_tick());
  endtask

  initial begin
    settings_used     = 0;
    hold_off_requests = 0;
    tx_gap_pct        = 0;
    rx_pause_pct      = 0;
    steps_by_mode     = '{default: 0};
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_off_after_reset();
    test_step_threshold();
    test_fade_clamp();
    test_fill_and_off();
    test_random_phases();
    test_backpressure();

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d result transfers over %0d register settings.",
             frames_checked, settings_used);
    $display("Effect steps: bounce %0d, fade %0d, fill %0d.",
             steps_by_mode[MODE_BOUNCE], steps_by_mode[MODE_FADE], steps_by_mode[MODE_FILL]);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
